>>> rtl/core/whp_pkg.sv
// Package: types and constants of the WAV header parser.
`default_nettype none

package whp_pkg;

    typedef enum logic [3:0] {
        PH_RIFF   = 4'd0,
        PH_RSIZE  = 4'd1,
        PH_WAVE   = 4'd2,
        PH_FMT    = 4'd3,
        PH_FSIZE  = 4'd4,
        PH_FORMAT = 4'd5,
        PH_CHAN   = 4'd6,
        PH_RATE   = 4'd7,
        PH_BRATE  = 4'd8,
        PH_ALIGN  = 4'd9,
        PH_BITS   = 4'd10,
        PH_TAG    = 4'd11,
        PH_LSIZE  = 4'd12,
        PH_SKIP   = 4'd13,
        PH_DTAG   = 4'd14,
        PH_DSIZE  = 4'd15
    } t_phase;

    localparam logic [3:0] ST_OK        = 4'd0;
    localparam logic [3:0] ST_RIFF_ID   = 4'd1;
    localparam logic [3:0] ST_RIFF_SIZE = 4'd2;
    localparam logic [3:0] ST_WAVE_ID   = 4'd3;
    localparam logic [3:0] ST_FMT_ID    = 4'd4;
    localparam logic [3:0] ST_FMT_SIZE  = 4'd5;
    localparam logic [3:0] ST_FORMAT    = 4'd6;
    localparam logic [3:0] ST_CHANNELS  = 4'd7;
    localparam logic [3:0] ST_BITS      = 4'd8;
    localparam logic [3:0] ST_LIST_SIZE = 4'd9;
    localparam logic [3:0] ST_DATA_ID   = 4'd10;

    localparam logic [31:0] TAG_RIFF = 32'h5249_4646;
    localparam logic [31:0] TAG_WAVE = 32'h5741_5645;
    localparam logic [31:0] TAG_FMT  = 32'h666D_7420;
    localparam logic [31:0] TAG_LIST = 32'h4C49_5354;
    localparam logic [31:0] TAG_DATA = 32'h6461_7461;

    localparam logic [31:0] FMT_CHUNK_SIZE = 32'h0000_0010;
    localparam logic [15:0] FMT_PCM        = 16'h0001;
    localparam logic [31:0] RIFF_HDR_BYTES = 32'd8;
    localparam int unsigned LIST_TAG_END   = 44;

    localparam int unsigned TDATA_W = 128;

    typedef struct packed {
        logic [3:0]  status;
        logic [1:0]  num_channels;
        logic [31:0] sample_hz;
        logic [31:0] byte_rate;
        logic [15:0] block_align;
        logic [4:0]  sample_width;
        logic [31:0] data_size;
        logic [8:0]  header_length;
    } t_result;

endpackage

`default_nettype wire

>>> rtl/core/whp_in_reg.sv
// Input register: holds one accepted header byte until the parser takes it.
`default_nettype none

module whp_in_reg (
    input  wire        i_clk,
    input  wire        i_rst_n,
    input  wire        i_valid,
    output logic       o_ready,
    input  wire  [7:0] i_byte,
    input  wire        i_first,
    output logic       o_valid,
    output logic [7:0] o_byte,
    output logic       o_first,
    input  wire        i_take
);

    logic       r_valid;
    logic [7:0] r_byte;
    logic       r_first;

    assign o_ready = !r_valid || i_take;
    assign o_valid = r_valid;
    assign o_byte  = r_byte;
    assign o_first = r_first;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_byte  <= i_byte;
            r_first <= i_first;
        end
    end

endmodule

`default_nettype wire

>>> rtl/core/whp_parser.sv
// Parser: per-byte field gathering, header checks and result formation.
`default_nettype none

module whp_parser #(
    parameter int unsigned HEADER_LIMIT = 500
) (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire              i_go,
    input  wire  [7:0]       i_byte,
    input  wire              i_first,
    input  wire  [31:0]      i_file_size,
    output logic             o_res_valid,
    output whp_pkg::t_result o_res
);

    import whp_pkg::*;

    localparam int unsigned POS_W = $clog2(HEADER_LIMIT + 8);
    localparam int unsigned SKIP_W = $clog2(HEADER_LIMIT);
    localparam logic [31:0] LIST_MAX = 32'(HEADER_LIMIT - LIST_TAG_END);

    t_phase            r_phase, n_phase, phase_src;
    logic              r_finished;
    logic [1:0]        r_cnt, n_cnt, cnt_src;
    logic [POS_W-1:0]  r_pos, pos_src, pos_next;
    logic [SKIP_W-1:0] r_skip, n_skip, skip_src, skip_dec;
    logic [23:0]       r_gather, gather_src;
    logic [1:0]        r_chan, n_chan, chan_src;
    logic [31:0]       r_srate, n_srate, srate_src;
    logic [31:0]       r_brate, n_brate, brate_src;
    logic [15:0]       r_align, n_align, align_src;
    logic [4:0]        r_bits, n_bits, bits_src;

    logic              active;
    logic [2:0]        field_len;
    logic              field_done;
    logic [31:0]       w, le32;
    logic [15:0]       le16;
    logic              emit;
    logic [3:0]        emit_status;
    logic [31:0]       hlen_wide;

    assign active     = i_go && (i_first || !r_finished);
    assign phase_src  = i_first ? PH_RIFF : r_phase;
    assign cnt_src    = i_first ? 2'd0 : r_cnt;
    assign pos_src    = i_first ? '0 : r_pos;
    assign skip_src   = i_first ? '0 : r_skip;
    assign gather_src = i_first ? 24'd0 : r_gather;
    assign chan_src   = i_first ? 2'd0 : r_chan;
    assign srate_src  = i_first ? 32'd0 : r_srate;
    assign brate_src  = i_first ? 32'd0 : r_brate;
    assign align_src  = i_first ? 16'd0 : r_align;
    assign bits_src   = i_first ? 5'd0 : r_bits;

    assign pos_next = pos_src + 1'b1;
    assign skip_dec = (skip_src != '0) ? skip_src - 1'b1 : '0;
    assign w        = {gather_src, i_byte};
    assign le32     = {w[7:0], w[15:8], w[23:16], w[31:24]};
    assign le16     = {w[7:0], w[15:8]};

    always_comb begin
        case (phase_src)
            PH_FORMAT, PH_CHAN, PH_ALIGN, PH_BITS: field_len = 3'd2;
            PH_SKIP:                               field_len = 3'd1;
            default:                               field_len = 3'd4;
        endcase
    end

    assign field_done = ({1'b0, cnt_src} + 3'd1) == field_len;

    // next state
    always_comb begin
        n_phase     = phase_src;
        n_cnt       = field_done ? 2'd0 : cnt_src + 2'd1;
        n_skip      = skip_src;
        n_chan      = chan_src;
        n_srate     = srate_src;
        n_brate     = brate_src;
        n_align     = align_src;
        n_bits      = bits_src;
        emit        = 1'b0;
        emit_status = ST_OK;
        if (field_done) begin
            unique case (phase_src)
                PH_RIFF: begin
                    if (w != TAG_RIFF) begin
                        emit = 1'b1; emit_status = ST_RIFF_ID;
                    end else begin
                        n_phase = PH_RSIZE;
                    end
                end
                PH_RSIZE: begin
                    if (le32 + RIFF_HDR_BYTES != i_file_size) begin
                        emit = 1'b1; emit_status = ST_RIFF_SIZE;
                    end else begin
                        n_phase = PH_WAVE;
                    end
                end
                PH_WAVE: begin
                    if (w != TAG_WAVE) begin
                        emit = 1'b1; emit_status = ST_WAVE_ID;
                    end else begin
                        n_phase = PH_FMT;
                    end
                end
                PH_FMT: begin
                    if (w != TAG_FMT) begin
                        emit = 1'b1; emit_status = ST_FMT_ID;
                    end else begin
                        n_phase = PH_FSIZE;
                    end
                end
                PH_FSIZE: begin
                    if (le32 != FMT_CHUNK_SIZE) begin
                        emit = 1'b1; emit_status = ST_FMT_SIZE;
                    end else begin
                        n_phase = PH_FORMAT;
                    end
                end
                PH_FORMAT: begin
                    if (le16 != FMT_PCM) begin
                        emit = 1'b1; emit_status = ST_FORMAT;
                    end else begin
                        n_phase = PH_CHAN;
                    end
                end
                PH_CHAN: begin
                    if (le16 != 16'd1 && le16 != 16'd2) begin
                        emit = 1'b1; emit_status = ST_CHANNELS;
                    end else begin
                        n_chan  = le16[1:0];
                        n_phase = PH_RATE;
                    end
                end
                PH_RATE: begin
                    n_srate = le32;
                    n_phase = PH_BRATE;
                end
                PH_BRATE: begin
                    n_brate = le32;
                    n_phase = PH_ALIGN;
                end
                PH_ALIGN: begin
                    n_align = le16;
                    n_phase = PH_BITS;
                end
                PH_BITS: begin
                    if (le16 != 16'd8 && le16 != 16'd16 && le16 != 16'd24) begin
                        emit = 1'b1; emit_status = ST_BITS;
                    end else begin
                        n_bits  = le16[4:0];
                        n_phase = PH_TAG;
                    end
                end
                PH_TAG: begin
                    if (w == TAG_LIST) begin
                        n_phase = PH_LSIZE;
                    end else if (w != TAG_DATA) begin
                        emit = 1'b1; emit_status = ST_DATA_ID;
                    end else begin
                        n_phase = PH_DSIZE;
                    end
                end
                PH_LSIZE: begin
                    if (le32 >= LIST_MAX) begin
                        emit = 1'b1; emit_status = ST_LIST_SIZE;
                    end else begin
                        n_skip  = le32[SKIP_W-1:0];
                        n_phase = (le32 == 32'd0) ? PH_DTAG : PH_SKIP;
                    end
                end
                PH_SKIP: begin
                    n_skip = skip_dec;
                    if (skip_dec == '0) begin
                        n_phase = PH_DTAG;
                    end
                end
                PH_DTAG: begin
                    if (w != TAG_DATA) begin
                        emit = 1'b1; emit_status = ST_DATA_ID;
                    end else begin
                        n_phase = PH_DSIZE;
                    end
                end
                PH_DSIZE: begin
                    emit        = 1'b1;
                    emit_status = ST_OK;
                end
            endcase
        end
    end

    // outputs
    assign hlen_wide = 32'(pos_next);

    always_comb begin
        o_res_valid         = active && emit;
        o_res.status        = emit_status;
        o_res.num_channels  = chan_src;
        o_res.sample_hz     = srate_src;
        o_res.byte_rate     = brate_src;
        o_res.block_align   = align_src;
        o_res.sample_width  = bits_src;
        o_res.data_size     = (emit_status == ST_OK) ? le32 : 32'd0;
        o_res.header_length = (emit_status == ST_OK) ? hlen_wide[8:0] : 9'd0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= PH_RIFF;
            r_finished <= 1'b1;
            r_cnt      <= 2'd0;
            r_pos      <= '0;
            r_skip     <= '0;
        end else if (active) begin
            r_phase    <= n_phase;
            r_finished <= emit;
            r_cnt      <= n_cnt;
            r_pos      <= pos_next;
            r_skip     <= n_skip;
        end
    end

    always_ff @(posedge i_clk) begin
        if (active) begin
            r_gather <= w[23:0];
            r_chan   <= n_chan;
            r_srate  <= n_srate;
            r_brate  <= n_brate;
            r_align  <= n_align;
            r_bits   <= n_bits;
        end
    end

endmodule

`default_nettype wire

>>> rtl/core/whp_out_reg.sv
// Output register: holds one parse result until the receiver takes it.
`default_nettype none

module whp_out_reg (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    input  wire                              i_load,
    input  whp_pkg::t_result                 i_res,
    output logic                             o_free,
    output logic                             o_tvalid,
    input  wire                              i_tready,
    output logic [whp_pkg::TDATA_W-1:0]      o_tdata,
    output logic [3:0]                       o_tuser
);

    import whp_pkg::*;

    logic                r_valid;
    logic [TDATA_W-1:0]  r_data;
    logic [3:0]          r_status;

    assign o_free   = !r_valid || i_tready;
    assign o_tvalid = r_valid;
    assign o_tdata  = r_data;
    assign o_tuser  = r_status;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_free) begin
            r_valid <= i_load;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_free && i_load) begin
            r_status <= i_res.status;
            r_data   <= {i_res.header_length, i_res.data_size, i_res.sample_width,
                         i_res.block_align, i_res.byte_rate, i_res.sample_hz,
                         i_res.num_channels};
        end
    end

endmodule

`default_nettype wire

>>> rtl/core/wav_header_parser_top.sv
// Top level of the WAV header parser.
//
// Input stream: one header byte per transfer on tdata; tuser high marks the
// first byte of a header and restarts parsing. Bytes without a mark after a
// finished header (or after reset) are dropped.
// Output stream: at most one transfer per header, at the first failed check or after
// the data chunk size; tuser carries the status code, tdata the parsed fields.
// Configuration: i_cfg_we writes the expected file size; write only while idle.
// Throughput: one byte per cycle while the receiver keeps tready high.
// Registers: an accepted byte waits in the input register and is parsed once the
// output register is free, which then takes its result (one register stage in, one out).
// Reset clears the parser; it then waits for a marked first byte, and the
// expected file size returns to zero.
// When the receiver stalls with a result pending, the parser holds; the input register
// keeps at most one waiting byte, and tready stays low while it is full.
`default_nettype none

module wav_header_parser_top #(
    parameter int unsigned HEADER_LIMIT = 500
) (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    // tdata: [7:0] header_byte
    input  wire  [7:0]                   i_s_axis_tdata,
    // tuser: [0] first_of_header
    input  wire  [0:0]                   i_s_axis_tuser,
    input  wire                          i_s_axis_tvalid,
    output logic                         o_s_axis_tready,
    // tdata: [1:0] num_channels, [33:2] sample_hz, [65:34] byte_rate,
    // [81:66] block_align, [86:82] sample_width, [118:87] data_size,
    // [127:119] header_length
    output logic [whp_pkg::TDATA_W-1:0]  o_m_axis_tdata,
    // tuser: [3:0] status
    output logic [3:0]                   o_m_axis_tuser,
    output logic                         o_m_axis_tvalid,
    input  wire                          i_m_axis_tready,
    input  wire                          i_cfg_we,
    input  wire  [31:0]                  i_cfg_wdata
);

    import whp_pkg::*;

    logic [31:0] r_exp_size;
    logic        in_valid;
    logic [7:0]  in_byte;
    logic        in_first;
    logic        out_free;
    logic        proc_go;
    logic        res_valid;
    t_result     res;

    assign proc_go = in_valid && out_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_exp_size <= 32'd0;
        end else if (i_cfg_we) begin
            r_exp_size <= i_cfg_wdata;
        end
    end

    whp_in_reg u_in_reg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_s_axis_tvalid),
        .o_ready (o_s_axis_tready),
        .i_byte  (i_s_axis_tdata),
        .i_first (i_s_axis_tuser[0]),
        .o_valid (in_valid),
        .o_byte  (in_byte),
        .o_first (in_first),
        .i_take  (proc_go)
    );

    whp_parser #(
        .HEADER_LIMIT (HEADER_LIMIT)
    ) u_parser (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_go        (proc_go),
        .i_byte      (in_byte),
        .i_first     (in_first),
        .i_file_size (r_exp_size),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    whp_out_reg u_out_reg (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (res_valid),
        .i_res    (res),
        .o_free   (out_free),
        .o_tvalid (o_m_axis_tvalid),
        .i_tready (i_m_axis_tready),
        .o_tdata  (o_m_axis_tdata),
        .o_tuser  (o_m_axis_tuser)
    );

    a_status_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> o_m_axis_tuser <= ST_DATA_ID)
        else $error("status code out of range");

    a_ok_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && o_m_axis_tuser == ST_OK) |->
            (o_m_axis_tdata[1:0] != 2'd0 && o_m_axis_tdata[86:82] != 5'd0))
        else $error("ok result without channels or sample width");

    a_stall_keeps_byte: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_valid && !proc_go) |=> in_valid)
        else $error("stalled input byte lost");

    a_result_needs_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        res_valid |-> out_free)
        else $error("result formed with output register full");

endmodule

`default_nettype wire

>>> tb/tb.sv
`timescale 1ns / 100ps
// Testbench of wav_header_parser_top: sends byte streams, predicts each parse report, checks it.
module tb;
    import whp_pkg::*;

    localparam int unsigned LIMIT      = 500;
    localparam int unsigned HOLD_OFF   = 300;
    localparam int unsigned RAND_BYTES = 200;
    localparam int          NO_LIST    = -1;

    localparam int OFS_RSIZE  = 4;
    localparam int OFS_WAVE   = 8;
    localparam int OFS_FMT    = 12;
    localparam int OFS_FSIZE  = 16;
    localparam int OFS_FORMAT = 20;
    localparam int OFS_CHAN   = 22;
    localparam int OFS_BITS   = 34;
    localparam int OFS_TAG    = 36;
    localparam int OFS_LSIZE  = 40;

    logic               i_clk    = 1'b0;
    logic               i_rst_n  = 1'b0;
    logic [7:0]         s_byte   = '0;
    logic               s_first  = 1'b0;
    logic               s_valid  = 1'b0;
    logic               s_ready;
    logic [TDATA_W-1:0] m_data;
    logic [3:0]         m_status;
    logic               m_valid;
    logic               m_ready  = 1'b0;
    logic               cfg_we   = 1'b0;
    logic [31:0]        cfg_data = '0;

    // parser model state
    logic [31:0] file_size_reg;
    int unsigned hdr_pos;
    int unsigned skip_left;
    int unsigned field_fill;
    t_phase      phase;
    logic [31:0] gathered;
    t_result     held;
    bit          idle_until_mark;
    t_result     expected_reports[$];
    t_result     next_report;

    logic [7:0]  frame_bytes[$];
    int unsigned bytes_sent   = 0;
    int unsigned mismatches   = 0;
    int unsigned hold_request = 0;
    bit          no_gaps      = 1'b0;

    always #5 i_clk = ~i_clk;

    wav_header_parser_top #(.HEADER_LIMIT(LIMIT)) dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tdata  (s_byte),
        .i_s_axis_tuser  (s_first),
        .i_s_axis_tvalid (s_valid),
        .o_s_axis_tready (s_ready),
        .o_m_axis_tdata  (m_data),
        .o_m_axis_tuser  (m_status),
        .o_m_axis_tvalid (m_valid),
        .i_m_axis_tready (m_ready),
        .i_cfg_we        (cfg_we),
        .i_cfg_wdata     (cfg_data)
    );

    task automatic restart_parse();
        hdr_pos = 0;
        phase = PH_RIFF;
        gathered = '0;
        skip_left = 0;
        field_fill = 0;
        held = '0;
    endtask

    function automatic int unsigned field_bytes(t_phase ph);
        case (ph)
            PH_FORMAT, PH_CHAN, PH_ALIGN, PH_BITS: return 2;
            PH_SKIP: return 1;
            default: return 4;
        endcase
    endfunction

    task automatic parse_byte(input logic [7:0] b, input logic mark);
        logic [31:0] le32;
        logic [15:0] le16;
        logic [3:0]  st;
        bit          done;
        t_result     rep;
        if (mark) begin
            restart_parse();
            idle_until_mark = 1'b0;
        end else if (idle_until_mark) begin
            return;
        end
        hdr_pos++;
        gathered = {gathered[23:0], b};
        field_fill++;
        if (field_fill < field_bytes(phase)) return;
        field_fill = 0;
        le32 = {gathered[7:0], gathered[15:8], gathered[23:16], gathered[31:24]};
        le16 = {gathered[7:0], gathered[15:8]};
        done = 1'b0;
        st = ST_OK;
        rep = '0;
        case (phase)
            PH_RIFF: begin
                if (gathered != TAG_RIFF) begin
                    done = 1'b1;
                    st = ST_RIFF_ID;
                end else phase = PH_RSIZE;
            end
            PH_RSIZE: begin
                if (le32 + RIFF_HDR_BYTES != file_size_reg) begin
                    done = 1'b1;
                    st = ST_RIFF_SIZE;
                end else phase = PH_WAVE;
            end
            PH_WAVE: begin
                if (gathered != TAG_WAVE) begin
                    done = 1'b1;
                    st = ST_WAVE_ID;
                end else phase = PH_FMT;
            end
            PH_FMT: begin
                if (gathered != TAG_FMT) begin
                    done = 1'b1;
                    st = ST_FMT_ID;
                end else phase = PH_FSIZE;
            end
            PH_FSIZE: begin
                if (le32 != FMT_CHUNK_SIZE) begin
                    done = 1'b1;
                    st = ST_FMT_SIZE;
                end else phase = PH_FORMAT;
            end
            PH_FORMAT: begin
                if (le16 != FMT_PCM) begin
                    done = 1'b1;
                    st = ST_FORMAT;
                end else phase = PH_CHAN;
            end
            PH_CHAN: begin
                if (le16 != 16'd1 && le16 != 16'd2) begin
                    done = 1'b1;
                    st = ST_CHANNELS;
                end else begin
                    held.num_channels = le16[1:0];
                    phase = PH_RATE;
                end
            end
            PH_RATE: begin
                held.sample_hz = le32;
                phase = PH_BRATE;
            end
            PH_BRATE: begin
                held.byte_rate = le32;
                phase = PH_ALIGN;
            end
            PH_ALIGN: begin
                held.block_align = le16;
                phase = PH_BITS;
            end
            PH_BITS: begin
                if (le16 != 16'd8 && le16 != 16'd16 && le16 != 16'd24) begin
                    done = 1'b1;
                    st = ST_BITS;
                end else begin
                    held.sample_width = le16[4:0];
                    phase = PH_TAG;
                end
            end
            PH_TAG: begin
                if (gathered == TAG_LIST) phase = PH_LSIZE;
                else if (gathered != TAG_DATA) begin
                    done = 1'b1;
                    st = ST_DATA_ID;
                end else phase = PH_DSIZE;
            end
            PH_LSIZE: begin
                if (64'(hdr_pos) + 64'(le32) >= 64'(LIMIT)) begin
                    done = 1'b1;
                    st = ST_LIST_SIZE;
                end else begin
                    skip_left = le32;
                    phase = (le32 == 0) ? PH_DTAG : PH_SKIP;
                end
            end
            PH_SKIP: begin
                if (skip_left > 0) skip_left--;
                if (skip_left == 0) phase = PH_DTAG;
            end
            PH_DTAG: begin
                if (gathered != TAG_DATA) begin
                    done = 1'b1;
                    st = ST_DATA_ID;
                end else phase = PH_DSIZE;
            end
            default: begin
                done = 1'b1;
                rep.data_size = le32;
                rep.header_length = hdr_pos[8:0];
            end
        endcase
        if (done) begin
            rep.status = st;
            rep.num_channels = held.num_channels;
            rep.sample_hz = held.sample_hz;
            rep.byte_rate = held.byte_rate;
            rep.block_align = held.block_align;
            rep.sample_width = held.sample_width;
            expected_reports.push_back(rep);
            idle_until_mark = 1'b1;
        end
    endtask

    task automatic check_field(input string what, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got) begin
            $display("%0t: %s expected %0h actual %0h", $time, what, want, got);
            mismatches++;
        end
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && m_valid && m_ready) begin
            if (expected_reports.size() == 0) begin
                $display("%0t: report with none expected, status %0d", $time, m_status);
                mismatches++;
            end else begin
                next_report = expected_reports.pop_front();
                check_field("status", next_report.status, m_status);
                check_field("num_channels", next_report.num_channels, m_data[1:0]);
                check_field("sample_hz", next_report.sample_hz, m_data[33:2]);
                check_field("byte_rate", next_report.byte_rate, m_data[65:34]);
                check_field("block_align", next_report.block_align, m_data[81:66]);
                check_field("sample_width", next_report.sample_width, m_data[86:82]);
                check_field("data_size", next_report.data_size, m_data[118:87]);
                check_field("header_length", next_report.header_length, m_data[127:119]);
            end
        end
    end

    function automatic int unsigned pick_gap();
        return no_gaps ? 0 : $urandom_range(0, 17);
    endfunction

    // receiver: random stall per transfer, long hold-off on request
    initial begin
        int unsigned stall;
        wait (i_rst_n);
        forever begin
            if (hold_request != 0) begin
                stall = hold_request;
                hold_request = 0;
            end else begin
                stall = pick_gap();
            end
            @(negedge i_clk);
            if (stall != 0) begin
                m_ready = 1'b0;
                repeat (stall) @(negedge i_clk);
            end
            m_ready = 1'b1;
            do @(posedge i_clk); while (!m_valid);
        end
    end

    task automatic send_byte(input logic [7:0] b, input logic mark);
        int unsigned gap;
        gap = pick_gap();
        @(negedge i_clk);
        if (gap != 0) begin
            s_valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        s_byte = b;
        s_first = mark;
        s_valid = 1'b1;
        do @(posedge i_clk); while (!s_ready);
        parse_byte(b, mark);
        bytes_sent++;
    endtask

    task automatic drain();
        @(negedge i_clk);
        s_valid = 1'b0;
        while (expected_reports.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_file_size(input logic [31:0] v);
        @(negedge i_clk);
        cfg_we = 1'b1;
        cfg_data = v;
        @(negedge i_clk);
        cfg_we = 1'b0;
        file_size_reg = v;
    endtask

    task automatic put_le(input logic [31:0] v, input int n);
        for (int i = 0; i < n; i++) frame_bytes.push_back(v[8*i +: 8]);
    endtask

    task automatic put_tag(input logic [31:0] t);
        for (int i = 3; i >= 0; i--) frame_bytes.push_back(t[8*i +: 8]);
    endtask

    task automatic set_le(input int at, input logic [31:0] v, input int n);
        for (int i = 0; i < n; i++) frame_bytes[at + i] = v[8*i +: 8];
    endtask

    // well-formed header for the file size unless LIST is too long; list_len < 0 omits LIST
    task automatic build_wav(input int list_len);
        logic [15:0] bits;
        frame_bytes.delete();
        put_tag(TAG_RIFF);
        put_le(file_size_reg - RIFF_HDR_BYTES, 4);
        put_tag(TAG_WAVE);
        put_tag(TAG_FMT);
        put_le(FMT_CHUNK_SIZE, 4);
        put_le(32'(FMT_PCM), 2);
        put_le($urandom_range(1, 2), 2);
        put_le($urandom, 4);
        put_le($urandom, 4);
        put_le($urandom, 2);
        case ($urandom_range(0, 2))
            0: bits = 16'd8;
            1: bits = 16'd16;
            default: bits = 16'd24;
        endcase
        put_le(32'(bits), 2);
        if (list_len >= 0) begin
            put_tag(TAG_LIST);
            put_le(list_len, 4);
            if (LIST_TAG_END + list_len >= LIMIT) return;
            repeat (list_len) frame_bytes.push_back(8'($urandom));
        end
        put_tag(TAG_DATA);
        put_le($urandom, 4);
    endtask

    task automatic send_prefix(input int n);
        for (int i = 0; i < n; i++) send_byte(frame_bytes[i], i == 0);
    endtask

    task automatic send_frame();
        send_prefix(frame_bytes.size());
    endtask

    task automatic send_patched(input int list_len, input int at, input logic [31:0] v,
                                input int n);
        build_wav(list_len);
        set_le(at, v, n);
        send_frame();
    endtask

    task automatic send_noise(input int n);
        repeat (n) send_byte(8'($urandom), 1'b0);
    endtask

    task automatic test_ignored_before_mark();
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_noise(3);
        build_wav(NO_LIST);
        send_frame();
        send_byte(8'hFF, 1'b0);
        drain();
    endtask

    task automatic test_valid_headers();
        write_file_size(32'd1000);
        send_patched(NO_LIST, OFS_BITS, 8, 2);
        send_patched(0, OFS_BITS, 16, 2);
        send_patched(7, OFS_BITS, 24, 2);
        send_patched(NO_LIST, OFS_CHAN, 1, 2);
        send_patched(NO_LIST, OFS_CHAN, 2, 2);
        build_wav(455);
        send_frame();
        drain();
    endtask

    task automatic test_each_check();
        write_file_size($urandom);
        send_patched(NO_LIST, 0, 8'h00, 1);
        send_noise(2);
        send_patched(NO_LIST, OFS_RSIZE, file_size_reg - 7, 4);
        send_patched(NO_LIST, OFS_WAVE + 3, 8'h46, 1);
        send_patched(NO_LIST, OFS_FMT, 8'hFF, 1);
        send_patched(NO_LIST, OFS_FSIZE, 17, 4);
        send_patched(NO_LIST, OFS_FSIZE, 32'h0001_0010, 4);
        send_patched(NO_LIST, OFS_FORMAT, 3, 2);
        send_patched(NO_LIST, OFS_FORMAT, 16'h0101, 2);
        send_patched(NO_LIST, OFS_CHAN, 0, 2);
        send_patched(NO_LIST, OFS_CHAN, 3, 2);
        send_patched(NO_LIST, OFS_BITS, 7, 2);
        send_patched(NO_LIST, OFS_BITS, 16'h0108, 2);
        send_patched(0, OFS_LSIZE, LIMIT - LIST_TAG_END, 4);
        send_patched(0, OFS_LSIZE, 32'hFFFF_FFFF, 4);
        send_patched(NO_LIST, OFS_TAG, 8'h65, 1);
        send_patched(3, OFS_TAG + 3, 8'h55, 1);
        send_patched(3, LIST_TAG_END + 3, 8'h00, 1);
        send_noise(2);
        drain();
    endtask

    task automatic test_restart_mid_header();
        build_wav(NO_LIST);
        send_prefix(20);
        build_wav(10);
        send_prefix(48);
        build_wav(NO_LIST);
        send_frame();
        drain();
    endtask

    task automatic test_file_size_extremes();
        write_file_size(32'd0);
        build_wav(NO_LIST);
        send_frame();
        send_patched(NO_LIST, OFS_RSIZE, 32'h0000_0000, 4);
        drain();
        write_file_size(32'hFFFF_FFFF);
        build_wav(2);
        send_frame();
        send_patched(NO_LIST, OFS_RSIZE, 32'hFFFF_FFFF, 4);
        drain();
        write_file_size(32'd8);
        build_wav(NO_LIST);
        send_frame();
        drain();
    endtask

    task automatic test_backpressure();
        no_gaps = 1'b1;
        hold_request = HOLD_OFF;
        for (int n = 0; n < 6; n++) begin
            build_wav(NO_LIST);
            if (n % 2 == 0) set_le(0, 8'h00, 1);
            send_frame();
        end
        no_gaps = 1'b0;
        drain();
    endtask

    function automatic int pick_list_len();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 70) return NO_LIST;
        if (r < 95) return $urandom_range(0, 24);
        return $urandom_range(430, 470);
    endfunction

    task automatic test_random_stream();
        int unsigned start;
        int unsigned kind;
        int unsigned frames;
        start = bytes_sent;
        frames = 0;
        while (bytes_sent - start < RAND_BYTES) begin
            if (frames % 15 == 0) begin
                drain();
                case ($urandom_range(0, 3))
                    0: write_file_size(32'd0);
                    1: write_file_size(32'hFFFF_FFFF);
                    default: write_file_size($urandom);
                endcase
                no_gaps = ($urandom_range(0, 3) == 0);
            end
            frames++;
            kind = $urandom_range(0, 99);
            build_wav(pick_list_len());
            if (kind < 65) begin
                send_frame();
            end else if (kind < 82) begin
                set_le($urandom_range(0, frame_bytes.size() - 1), $urandom, 1);
                send_frame();
            end else if (kind < 92) begin
                send_prefix($urandom_range(1, frame_bytes.size() - 1));
            end else begin
                repeat ($urandom_range(1, 12))
                    send_byte(8'($urandom), $urandom_range(0, 7) == 0);
            end
            if ($urandom_range(0, 3) == 0) send_noise($urandom_range(1, 3));
        end
        no_gaps = 1'b0;
    endtask

    initial begin
        file_size_reg = '0;
        restart_parse();
        idle_until_mark = 1'b1;
        repeat (5) @(negedge i_clk);
        i_rst_n = 1'b1;
        test_ignored_before_mark();
        test_valid_headers();
        test_each_check();
        test_restart_mid_header();
        test_file_size_extremes();
        test_backpressure();
        test_random_stream();
        drain();
        if (mismatches == 0) begin
            $display("wav_header_parser_top verification clean");
        end else begin
            $display("wav_header_parser_top verification failed");
        end
        $finish;
    end

    initial begin
        #5_000_000;
        $display("wav_header_parser_top verification failed");
        $finish;
    end

endmodule
